/* src/triangle_barycentric_coords_macros.svh */
// Assertion macros used by the checker file of the barycentric block.
// No dependencies.
`ifndef TRIANGLE_BARYCENTRIC_COORDS_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_MACROS_SVH

// Clocked assertion that is off while reset is asserted.
`define BARY_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define BARY_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/bary_pkg.sv */
// Shared widths, register codes and the triangle vertex bundle.
// No dependencies.
package bary_pkg;
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int AREA_W  = 35;
    localparam int FRAC_W  = 12;
    localparam int QUOT_W  = 16;
    localparam int NUM_W   = 48;
    localparam int REM_W   = NUM_W + 4;
    localparam int CFG_IDX_W = 3;
    localparam int PRE_LAT = 3;
    localparam int DIV_LAT = QUOT_W + 3;
    localparam int LATENCY = PRE_LAT + DIV_LAT;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_U = 3'd0,
        REG_A_V = 3'd1,
        REG_B_U = 3'd2,
        REG_B_V = 3'd3,
        REG_C_U = 3'd4,
        REG_C_V = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] au;
        logic signed [COORD_W-1:0] av;
        logic signed [COORD_W-1:0] bu;
        logic signed [COORD_W-1:0] bv;
        logic signed [COORD_W-1:0] cu;
        logic signed [COORD_W-1:0] cv;
    } tri_t;

    typedef struct packed {
        logic                 degen;
        logic                 neg;
        logic [AREA_W:0]      d2;
    } den_t;
endpackage

/* src/triangle_barycentric_coords.sv */
// Top level of the barycentric weight pipeline.
// Depends on bary_pkg, bary_area, bary_subarea and bary_div.
//
//  channel  dir  payload
//  s_*      in   tdata: point_u, point_v
//  m_*      out  tdata: weight_a, weight_b, weight_c; tuser: degenerate
//  cfg_*    in   cfg_index, cfg_data (vertex registers)
//
// Queries are accepted one per cycle while the output is not stalled; each
// divider holds a 16-stage quotient pipeline.
// A stall on the output freezes every stage; s_tready follows it.
// Reset clears all valid bits and loads zero vertices (degenerate).
// The triangle area follows a vertex write through area_reg and then den_reg.
module triangle_barycentric_coords import bary_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // point_u, point_v
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // weight_a, weight_b, weight_c
    output logic [0:0]           m_tuser,   // degenerate
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);
    tri_t tri_w;
    den_t den_w;
    logic en;
    logic [LATENCY-1:0] vld_reg, vld_next;
    logic signed [AREA_W-1:0] sa, sb, sc;
    logic signed [QUOT_W-1:0] wa, wb, wc;

    assign cfg_ready = 1'b1;
    assign en        = !vld_reg[LATENCY-1] || m_tready;
    assign s_tready  = en;
    assign vld_next  = {vld_reg[LATENCY-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    bary_area u_area (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .tri_out  (tri_w),
        .den_out  (den_w)
    );

    bary_subarea u_sub (
        .aclk   (aclk),
        .en     (en),
        .tri_in (tri_w),
        .pu     (s_tdata[15:0]),
        .pv     (s_tdata[31:16]),
        .area_a (sa),
        .area_b (sb),
        .area_c (sc)
    );

    bary_div u_div_a (.aclk(aclk), .en(en), .num(sa), .den(den_w), .weight(wa));
    bary_div u_div_b (.aclk(aclk), .en(en), .num(sb), .den(den_w), .weight(wb));
    bary_div u_div_c (.aclk(aclk), .en(en), .num(sc), .den(den_w), .weight(wc));

    assign m_tvalid = vld_reg[LATENCY-1];
    assign m_tdata  = {wc, wb, wa};
    assign m_tuser  = den_w.degen;
endmodule

/* src/bary_area.sv */
// Vertex registers and the twice-area of the whole triangle.
// Depends on bary_pkg.
module bary_area import bary_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [COORD_W-1:0]   wr_data,
    output tri_t                 tri_out,
    output den_t                 den_out
);
    tri_t tri_reg, tri_next;
    logic signed [AREA_W-1:0] area_reg, area_next;
    den_t den_reg, den_next;
    logic signed [DIFF_W-1:0] e1u, e1v, e2u, e2v;
    logic signed [PROD_W-1:0] p1, p2;
    logic [AREA_W-1:0] mag;

    always_comb begin
        tri_next = tri_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_A_U: tri_next.au = wr_data;
                REG_A_V: tri_next.av = wr_data;
                REG_B_U: tri_next.bu = wr_data;
                REG_B_V: tri_next.bv = wr_data;
                REG_C_U: tri_next.cu = wr_data;
                REG_C_V: tri_next.cv = wr_data;
                default: tri_next = tri_reg;
            endcase
        end
        e1u = DIFF_W'(tri_reg.bu) - DIFF_W'(tri_reg.au);
        e1v = DIFF_W'(tri_reg.bv) - DIFF_W'(tri_reg.av);
        e2u = DIFF_W'(tri_reg.cu) - DIFF_W'(tri_reg.au);
        e2v = DIFF_W'(tri_reg.cv) - DIFF_W'(tri_reg.av);
        p1 = e1u * e2v;
        p2 = e2u * e1v;
        area_next = AREA_W'(p1) - AREA_W'(p2);
        mag = area_reg[AREA_W-1] ? AREA_W'(-area_reg) : AREA_W'(area_reg);
        den_next.degen = (area_reg == '0);
        den_next.neg   = area_reg[AREA_W-1];
        den_next.d2    = {mag, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tri_reg  <= '0;
            area_reg <= '0;
            den_reg  <= '{degen: 1'b1, neg: 1'b0, d2: '0};
        end else begin
            tri_reg  <= tri_next;
            area_reg <= area_next;
            den_reg  <= den_next;
        end
    end

    assign tri_out = tri_reg;
    assign den_out = den_reg;
endmodule

/* src/bary_subarea.sv */
// Three-stage pipeline forming the three sub-triangle twice-areas.
// Depends on bary_pkg.
module bary_subarea import bary_pkg::*; (
    input  logic                      aclk,
    input  logic                      en,
    input  tri_t                      tri_in,
    input  logic signed [COORD_W-1:0] pu,
    input  logic signed [COORD_W-1:0] pv,
    output logic signed [AREA_W-1:0]  area_a,
    output logic signed [AREA_W-1:0]  area_b,
    output logic signed [AREA_W-1:0]  area_c
);
    logic signed [DIFF_W-1:0] du_reg [3];
    logic signed [DIFF_W-1:0] dv_reg [3];
    logic signed [PROD_W-1:0] prod_reg [6];
    logic signed [AREA_W-1:0] sub_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            du_reg[0] <= DIFF_W'(tri_in.au) - DIFF_W'(pu);
            du_reg[1] <= DIFF_W'(tri_in.bu) - DIFF_W'(pu);
            du_reg[2] <= DIFF_W'(tri_in.cu) - DIFF_W'(pu);
            dv_reg[0] <= DIFF_W'(tri_in.av) - DIFF_W'(pv);
            dv_reg[1] <= DIFF_W'(tri_in.bv) - DIFF_W'(pv);
            dv_reg[2] <= DIFF_W'(tri_in.cv) - DIFF_W'(pv);
            prod_reg[0] <= du_reg[1] * dv_reg[2];
            prod_reg[1] <= du_reg[2] * dv_reg[1];
            prod_reg[2] <= du_reg[2] * dv_reg[0];
            prod_reg[3] <= du_reg[0] * dv_reg[2];
            prod_reg[4] <= du_reg[0] * dv_reg[1];
            prod_reg[5] <= du_reg[1] * dv_reg[0];
            sub_reg[0] <= AREA_W'(prod_reg[0]) - AREA_W'(prod_reg[1]);
            sub_reg[1] <= AREA_W'(prod_reg[2]) - AREA_W'(prod_reg[3]);
            sub_reg[2] <= AREA_W'(prod_reg[4]) - AREA_W'(prod_reg[5]);
        end
    end

    assign area_a = sub_reg[0];
    assign area_b = sub_reg[1];
    assign area_c = sub_reg[2];
endmodule

/* src/bary_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with rounding
// and saturation to Q4.12 in the last stage. Depends on bary_pkg.
module bary_div import bary_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [AREA_W-1:0] num,
    input  den_t                     den,
    output logic signed [QUOT_W-1:0] weight
);
    logic [NUM_W-1:0]  n_reg;
    logic              neg_reg [QUOT_W+2];
    logic              ovf_reg [QUOT_W+1];
    logic [REM_W-1:0]  rem_reg [QUOT_W+1];
    logic [QUOT_W-1:0] q_reg   [QUOT_W+1];
    logic [AREA_W-1:0] mag;
    logic [REM_W-1:0]  dw;
    logic signed [QUOT_W-1:0] w_reg, w_next;

    assign mag = num[AREA_W-1] ? AREA_W'(-num) : AREA_W'(num);
    assign dw  = REM_W'(den.d2);

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= {mag[AREA_W-2:0], (FRAC_W+1)'(0)} + NUM_W'(den.d2[AREA_W:1]);
            neg_reg[0] <= num[AREA_W-1] ^ den.neg;
            rem_reg[0] <= REM_W'(n_reg);
            ovf_reg[0] <= REM_W'(n_reg) >= (dw << QUOT_W);
            q_reg[0]   <= '0;
            neg_reg[1] <= neg_reg[0];
        end
    end

    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
        localparam int SH = QUOT_W - 1 - k;
        logic [REM_W-1:0] sub;
        logic             take;
        assign sub  = dw << SH;
        assign take = rem_reg[k] >= sub;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]   <= take ? rem_reg[k] - sub : rem_reg[k];
                q_reg[k+1]     <= q_reg[k] | (QUOT_W'(take) << SH);
                ovf_reg[k+1]   <= ovf_reg[k];
                neg_reg[k+2]   <= neg_reg[k+1];
            end
        end
    end

    always_comb begin
        w_next = '0;
        if (!den.degen) begin
            if (neg_reg[QUOT_W+1]) begin
                if (ovf_reg[QUOT_W] || q_reg[QUOT_W] > {1'b1, (QUOT_W-1)'(0)}) begin
                    w_next = {1'b1, (QUOT_W-1)'(0)};
                end else begin
                    w_next = -q_reg[QUOT_W];
                end
            end else begin
                if (ovf_reg[QUOT_W] || q_reg[QUOT_W][QUOT_W-1]) begin
                    w_next = {1'b0, {(QUOT_W-1){1'b1}}};
                end else begin
                    w_next = q_reg[QUOT_W];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg <= w_next;
        end
    end

    assign weight = w_reg;
endmodule

/* src/bary_checker.sv */
// Port-level checker for the barycentric block, bound to the top level.
// Depends on triangle_barycentric_coords_macros.svh.
`include "triangle_barycentric_coords_macros.svh"

module bary_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        cfg_ready
);
    `BARY_ASSERT(a_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "output changed while stalled")
    `BARY_ASSERT(a_degen, aclk, aresetn,
        m_tvalid && m_tuser[0] |-> m_tdata == 48'd0,
        "degenerate result has nonzero weights")
    `BARY_ASSERT(a_ready, aclk, aresetn,
        s_tready == (!m_tvalid || m_tready),
        "input ready does not follow output stall")
    `BARY_ASSERT_ALWAYS(a_rst, aclk,
        !aresetn |=> !m_tvalid && cfg_ready,
        "output valid after reset")
endmodule

bind triangle_barycentric_coords bary_checker u_bary_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);
